// ===== rtl/che_pkg.sv =====
package che_pkg;

    localparam int TRIG_W     = 16;
    localparam int ORDER_W    = 3;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int HIDX_W     = 4;

    localparam logic [CFG_ADDR_W-1:0] REG_ORDER = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_COS   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SIN   = 2'd2;

    localparam logic [ORDER_W-1:0] ORDER_RST = 3'd1;

    typedef logic signed [TRIG_W-1:0] trig_t;

    localparam trig_t COS_RST = 16'sd16384;
    localparam trig_t SIN_RST = 16'sd0;

    // Q2.14 cosine/sine pair
    typedef struct packed {
        trig_t c;
        trig_t s;
    } trig_pair_t;

endpackage

// ===== rtl/che_cell.sv =====
module che_cell import che_pkg::*; #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int NUM_VALS     = 3,
    parameter int SLOT         = 1
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           adv,
    input  trig_pair_t                     base,
    input  logic                           in_valid,
    input  logic signed [SAMPLE_WIDTH-1:0] in_x,
    input  trig_pair_t                     in_trig,
    input  logic signed [SAMPLE_WIDTH-1:0] in_vals [NUM_VALS],
    output logic                           out_valid,
    output logic signed [SAMPLE_WIDTH-1:0] out_x,
    output trig_pair_t                     out_trig,
    output logic signed [SAMPLE_WIDTH-1:0] out_vals [NUM_VALS]
);

    localparam int PW = SAMPLE_WIDTH + TRIG_W;
    localparam int TW = 2 * TRIG_W + 1;
    localparam logic signed [PW-1:0] VMAX = PW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] VMIN = -VMAX - PW'(1);
    localparam logic signed [TW-1:0] TMAX = TW'(32767);
    localparam logic signed [TW-1:0] TMIN = -TMAX - TW'(1);

    function automatic logic signed [SAMPLE_WIDTH-1:0] round_val(
        input logic signed [PW-1:0] v
    );
        logic signed [PW-1:0] r;
        r = (v + PW'(8192)) >>> 14;
        if (r > VMAX) begin
            return VMAX[SAMPLE_WIDTH-1:0];
        end else if (r < VMIN) begin
            return VMIN[SAMPLE_WIDTH-1:0];
        end
        return r[SAMPLE_WIDTH-1:0];
    endfunction

    function automatic trig_t round_trig(input logic signed [TW-1:0] v);
        logic signed [TW-1:0] r;
        r = (v + TW'(8192)) >>> 14;
        if (r > TMAX) begin
            return TMAX[TRIG_W-1:0];
        end else if (r < TMIN) begin
            return TMIN[TRIG_W-1:0];
        end
        return r[TRIG_W-1:0];
    endfunction

    logic signed [PW-1:0]           px_s, px_c;
    logic signed [2*TRIG_W-1:0]     cc, ss, cs, sc;

    logic                           a_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] a_x_reg;
    logic signed [SAMPLE_WIDTH-1:0] a_vals_reg [NUM_VALS];
    logic signed [PW-1:0]           px_s_reg, px_c_reg;
    logic signed [2*TRIG_W-1:0]     cc_reg, ss_reg, cs_reg, sc_reg;

    logic                           b_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] b_x_reg;
    trig_pair_t                     b_trig_reg, b_trig_next;
    logic signed [SAMPLE_WIDTH-1:0] b_vals_reg  [NUM_VALS];
    logic signed [SAMPLE_WIDTH-1:0] b_vals_next [NUM_VALS];

    assign px_s = in_x * in_trig.s;
    assign px_c = in_x * in_trig.c;
    assign cc   = in_trig.c * base.c;
    assign ss   = in_trig.s * base.s;
    assign cs   = in_trig.c * base.s;
    assign sc   = in_trig.s * base.c;

    always_comb begin
        for (int i = 0; i < NUM_VALS; i++) begin
            b_vals_next[i] = a_vals_reg[i];
        end
        b_vals_next[SLOT]     = round_val(px_s_reg);
        b_vals_next[SLOT + 1] = round_val(px_c_reg);
        b_trig_next.c = round_trig(TW'(cc_reg) - TW'(ss_reg));
        b_trig_next.s = round_trig(TW'(cs_reg) + TW'(sc_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_x_reg    <= in_x;
            a_vals_reg <= in_vals;
            px_s_reg   <= px_s;
            px_c_reg   <= px_c;
            cc_reg     <= cc;
            ss_reg     <= ss;
            cs_reg     <= cs;
            sc_reg     <= sc;
            b_x_reg    <= a_x_reg;
            b_trig_reg <= b_trig_next;
            b_vals_reg <= b_vals_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_x     = b_x_reg;
    assign out_trig  = b_trig_reg;
    assign out_vals  = b_vals_reg;

endmodule

// ===== rtl/che_out.sv =====
module che_out import che_pkg::*; #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int NUM_VALS     = 3,
    parameter int IDX_W        = 2
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    input  logic signed [SAMPLE_WIDTH-1:0] in_vals [NUM_VALS],
    input  logic [IDX_W-1:0]               last_pos,
    output logic                           in_ready,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_value,
    output logic [HIDX_W-1:0]              m_index,
    output logic                           m_last
);

    logic                           valid_reg;
    logic [IDX_W-1:0]               pos_reg;
    logic signed [SAMPLE_WIDTH-1:0] vals_reg [NUM_VALS];

    assign m_last   = (pos_reg == last_pos);
    assign in_ready = !valid_reg || (m_ready && m_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
            pos_reg   <= '0;
        end else if (m_ready) begin
            pos_reg   <= pos_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            vals_reg <= in_vals;
        end
    end

    assign m_valid = valid_reg;
    assign m_value = vals_reg[pos_reg];
    assign m_index = HIDX_W'(pos_reg);

    a_pos_step: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && m_ready && !m_last |=> pos_reg == $past(pos_reg) + IDX_W'(1))
        else $error("result index did not advance");

    a_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && m_ready && m_last && in_valid |=> valid_reg && pos_reg == '0)
        else $error("next item not loaded after last result");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> pos_reg <= last_pos)
        else $error("result index past final harmonic");

endmodule

// ===== rtl/circular_harmonic_encoder_top.sv =====
// Two-dimensional circular harmonic encoder. Each sample item yields 2*order+1 result items:
// the sample itself (index 0), then sample*sin(k*az) (index 2k-1) and sample*cos(k*az)
// (index 2k) for k = 1..order, rounded half up to Q1.15 and saturated. The k*az terms come
// from the angle-addition recurrence seeded by the Q2.14 cos/sin registers. A chain of
// MAX_ORDER cells, two register stages each, computes all harmonics of an item while later
// items follow one per cycle behind it unless the chain stalls; a snapshot buffer then sends
// the results one per cycle while m_tready is high. Throughput is set by the single result
// port, which loads the next item as the last result of the current one is taken. Write the
// registers only while no item is in flight.
module circular_harmonic_encoder_top import che_pkg::*; #(
    parameter int MAX_ORDER    = 7,
    parameter int SAMPLE_WIDTH = 16,
    localparam int DATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_W-1:0]     s_tdata,   // sample
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_W-1:0]     m_tdata,   // value
    output logic [HIDX_W-1:0]     m_tuser,   // harmonic_index
    output logic                  m_tlast
);

    localparam int NUM_VALS = 2 * MAX_ORDER + 1;
    localparam int IDX_W    = $clog2(NUM_VALS);

    logic [ORDER_W-1:0] order_reg;
    trig_t              cos_reg, sin_reg;
    trig_pair_t         base;
    logic [IDX_W-1:0]   last_pos;
    logic               adv, out_ready;

    logic                           valid_c [MAX_ORDER+1];
    logic signed [SAMPLE_WIDTH-1:0] x_c     [MAX_ORDER+1];
    trig_pair_t                     trig_c  [MAX_ORDER+1];
    logic signed [SAMPLE_WIDTH-1:0] vals_c  [MAX_ORDER+1][NUM_VALS];

    logic signed [SAMPLE_WIDTH-1:0] value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= ORDER_RST;
            cos_reg   <= COS_RST;
            sin_reg   <= SIN_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_ORDER: order_reg <= cfg_wdata[ORDER_W-1:0];
                REG_COS:   cos_reg   <= cfg_wdata;
                REG_SIN:   sin_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (int'(order_reg) > MAX_ORDER) begin
            last_pos = IDX_W'(2 * MAX_ORDER);
        end else begin
            last_pos = IDX_W'({order_reg, 1'b0});
        end
    end

    assign base.c = cos_reg;
    assign base.s = sin_reg;

    assign adv      = !valid_c[MAX_ORDER] || out_ready;
    assign s_tready = adv;

    always_comb begin
        valid_c[0] = s_tvalid;
        x_c[0]     = s_tdata[SAMPLE_WIDTH-1:0];
        trig_c[0]  = base;
        for (int i = 0; i < NUM_VALS; i++) begin
            vals_c[0][i] = '0;
        end
        vals_c[0][0] = s_tdata[SAMPLE_WIDTH-1:0];
    end

    for (genvar k = 0; k < MAX_ORDER; k++) begin : g_cell
        che_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .NUM_VALS     (NUM_VALS),
            .SLOT         (2 * k + 1)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .base      (base),
            .in_valid  (valid_c[k]),
            .in_x      (x_c[k]),
            .in_trig   (trig_c[k]),
            .in_vals   (vals_c[k]),
            .out_valid (valid_c[k+1]),
            .out_x     (x_c[k+1]),
            .out_trig  (trig_c[k+1]),
            .out_vals  (vals_c[k+1])
        );
    end

    che_out #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .NUM_VALS     (NUM_VALS),
        .IDX_W        (IDX_W)
    ) u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (valid_c[MAX_ORDER]),
        .in_vals  (vals_c[MAX_ORDER]),
        .last_pos (last_pos),
        .in_ready (out_ready),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_value  (value),
        .m_index  (m_tuser),
        .m_last   (m_tlast)
    );

    assign m_tdata = DATA_W'($unsigned(value));

endmodule
